// ===== rtl/lrt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrt_pkg
// shared operation codes, result word layout and fixed field widths
// ----------------------------------------------------------------------------
package lrt_pkg;

    localparam int FUNC_W     = 2;
    localparam int CAP_W      = 5;
    localparam int SLOT_W     = 4;
    localparam int EKEY_W     = 32;
    localparam int COUNT_W    = 5;
    localparam int OUT_TDATA_W = 48;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_SEARCH = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    typedef struct packed {
        logic               ok;
        logic               was_present;
        logic [SLOT_W-1:0]  slot;
        logic               evicted;
        logic [EKEY_W-1:0]  evicted_key;
        logic [COUNT_W-1:0] count;
    } t_result;

endpackage : lrt_pkg
`default_nettype wire

// ===== rtl/lrt_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrt_table
// entry store with parallel key match, age ranks and per-step state update
// ----------------------------------------------------------------------------
module lrt_table
    import lrt_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_step,
    input  wire t_func               i_func,
    input  wire logic [KEY_BITS-1:0] i_key,
    input  wire logic [CAP_W-1:0]    i_capacity,
    output t_result                  o_result
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int KEXT_W = (KEY_BITS > EKEY_W) ? KEY_BITS : EKEY_W;
    localparam int SEXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int CEXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    logic [ENTRIES-1:0]  r_valid, n_valid;
    logic [IDX_W-1:0]    r_rank [ENTRIES];
    logic [IDX_W-1:0]    n_rank [ENTRIES];
    logic [KEY_BITS-1:0] r_key  [ENTRIES];
    logic [CNT_W-1:0]    r_count, n_count;

    logic [ENTRIES-1:0]  hit, oldest, evict_vec, kept, ins;
    logic                hit_any, full, add_miss, evict;
    logic [IDX_W-1:0]    hit_idx, ins_idx, hit_rank, oldest_rank;
    logic [KEY_BITS-1:0] old_key;
    logic [CMP_W-1:0]    cap_eff, cap_ext;
    logic [KEXT_W-1:0]   old_key_ext;
    logic [SEXT_W-1:0]   slot_ext;
    logic [CEXT_W-1:0]   count_ext;

    // capacity clamped to 1..ENTRIES
    always_comb begin
        cap_ext = CMP_W'(i_capacity);
        if (cap_ext == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_ext > CMP_W'(ENTRIES)) begin
            cap_eff = CMP_W'(ENTRIES);
        end else begin
            cap_eff = cap_ext;
        end
    end

    // ranks form a permutation of 0..count-1, so the oldest has rank count-1
    assign oldest_rank = IDX_W'(r_count - CNT_W'(1));

    always_comb begin
        hit_idx  = '0;
        hit_rank = '0;
        old_key  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit[i]    = r_valid[i] && (r_key[i] == i_key);
            oldest[i] = r_valid[i] && (r_rank[i] == oldest_rank);
            if (hit[i]) begin
                hit_idx  = hit_idx | IDX_W'(i);
                hit_rank = hit_rank | r_rank[i];
            end
            if (oldest[i]) begin
                old_key = old_key | r_key[i];
            end
        end
    end

    assign hit_any   = |hit;
    assign full      = CMP_W'(r_count) >= cap_eff;
    assign add_miss  = (i_func == FUNC_ADD) && !hit_any;
    assign evict     = add_miss && full;
    assign evict_vec = evict ? oldest : '0;
    assign kept      = r_valid & ~evict_vec;
    // lowest free slot after the eviction
    assign ins       = ~kept & (kept + ENTRIES'(1));

    always_comb begin
        ins_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (ins[i]) begin
                ins_idx = ins_idx | IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        n_count = r_count;
        case (i_func)
            FUNC_CLEAR: begin
                n_valid = '0;
                for (int i = 0; i < ENTRIES; i++) begin
                    n_rank[i] = '0;
                end
                n_count = '0;
            end
            FUNC_REMOVE: begin
                if (hit_any) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (r_valid[i] && r_rank[i] > hit_rank) begin
                            n_rank[i] = r_rank[i] - IDX_W'(1);
                        end
                        if (hit[i]) begin
                            n_valid[i] = 1'b0;
                            n_rank[i]  = '0;
                        end
                    end
                    n_count = r_count - CNT_W'(1);
                end
            end
            FUNC_ADD, FUNC_SEARCH: begin
                if (hit_any) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (r_valid[i] && r_rank[i] < hit_rank) begin
                            n_rank[i] = r_rank[i] + IDX_W'(1);
                        end
                        if (hit[i]) begin
                            n_rank[i] = '0;
                        end
                    end
                end else if (add_miss) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (kept[i]) begin
                            n_rank[i] = r_rank[i] + IDX_W'(1);
                        end else begin
                            n_rank[i] = '0;
                        end
                        n_valid[i] = kept[i] | ins[i];
                    end
                    n_count = r_count - CNT_W'(evict) + CNT_W'(1);
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_step) begin
            r_valid <= n_valid;
            r_count <= n_count;
            r_rank  <= n_rank;
        end
    end

    // key store, no reset
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_step && add_miss && ins[i]) begin
                r_key[i] <= i_key;
            end
        end
    end

    always_comb begin
        old_key_ext = evict ? KEXT_W'(old_key) : '0;
        if (hit_any && i_func != FUNC_CLEAR) begin
            slot_ext = SEXT_W'(hit_idx);
        end else if (add_miss) begin
            slot_ext = SEXT_W'(ins_idx);
        end else begin
            slot_ext = '0;
        end
        count_ext = CEXT_W'(n_count);
        o_result.ok          = (i_func == FUNC_CLEAR) || (i_func == FUNC_ADD) || hit_any;
        o_result.was_present = hit_any && (i_func != FUNC_CLEAR);
        o_result.slot        = slot_ext[SLOT_W-1:0];
        o_result.evicted     = evict;
        o_result.evicted_key = old_key_ext[EKEY_W-1:0];
        o_result.count       = count_ext[COUNT_W-1:0];
    end

    a_count_matches_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'($countones(r_valid)) == r_count)
        else $error("valid count differs from valid bits");

    a_single_hit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(hit))
        else $error("key matched in more than one entry");

    a_one_oldest : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && evict) |-> $onehot(oldest))
        else $error("eviction without a unique oldest entry");

    a_insert_slot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && add_miss) |-> $onehot(ins))
        else $error("add miss found no free slot");

endmodule : lrt_table
`default_nettype wire

// ===== rtl/lrt_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrt_out_reg
// result register and output word packing
// ----------------------------------------------------------------------------
module lrt_out_reg
    import lrt_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_load,
    input  wire t_result                i_result,
    output logic                        o_can_load,
    output logic                        o_tvalid,
    input  wire logic                   i_tready,
    output logic [OUT_TDATA_W-1:0]      o_tdata
);

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {4'b0, r_result.count, r_result.evicted_key, r_result.evicted,
                       r_result.slot, r_result.was_present, r_result.ok};

endmodule : lrt_out_reg
`default_nettype wire

// ===== rtl/lru_replacement_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_replacement_table
// fully associative key table with least-recently-used replacement
// ----------------------------------------------------------------------------
// Takes one word per clock unless the result stream stalls and returns one
// result word per word, via the input register and then the result register.
// All entry keys are compared in parallel and the age ranks, valid bits and
// count are rewritten in the same cycle that loads the result register, so
// the next word already sees the updated table. Operations are add, search,
// remove and clear; a hit on add or search makes the entry newest, an add
// miss evicts the oldest entry once the count has reached the capacity and
// then fills the lowest free slot. Capacity must be written over the config
// channel only while the block is idle (not enforced). 0 acts as 1 and values
// above ENTRIES act as ENTRIES. Keys of empty entries are never used.
// ----------------------------------------------------------------------------
module lru_replacement_table
    import lrt_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // func [1:0], key [KEY_BITS+1:2], zero fill to whole bytes
    input  wire logic [((KEY_BITS + FUNC_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // ok [0], was_present [1], slot [5:2], evicted [6], evicted_key [38:7],
    // count [43:39], zero fill [47:44]
    output logic [OUT_TDATA_W-1:0]     m_axis_tdata,
    // capacity config
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CAP_W-1:0]      i_cfg_data
);

    // input register
    logic                r_in_valid;
    t_func               r_in_func;
    logic [KEY_BITS-1:0] r_in_key;
    logic [CAP_W-1:0]    r_capacity;

    logic    can_load;
    logic    step;
    t_result result;

    // a word leaves the input register when the result register has room
    assign step          = r_in_valid && can_load;
    assign s_axis_tready = !r_in_valid || can_load;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_func <= t_func'(s_axis_tdata[FUNC_W-1:0]);
            r_in_key  <= s_axis_tdata[KEY_BITS+FUNC_W-1:FUNC_W];
        end
    end

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    // match, rank update and state write
    lrt_table #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_func     (r_in_func),
        .i_key      (r_in_key),
        .i_capacity (r_capacity),
        .o_result   (result)
    );

    // result register toward the output stream
    lrt_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step),
        .i_result   (result),
        .o_can_load (can_load),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_tdata    (m_axis_tdata)
    );

endmodule : lru_replacement_table
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the lru replacement table
// ----------------------------------------------------------------------------
// A short table of directed words and capacity writes comes first: lookups
// on an empty table, the all-zero and all-one keys, hits, removes, clear,
// capacity 1, 0, above the entry count and lowered below the live count.
// Then come random phases, each at its own capacity, with keys drawn mostly
// from a small pool so that hits, removes and evictions are common. Every
// result word is checked field by field against a local model or a preset value.
// ----------------------------------------------------------------------------
module testbench;
    import lrt_pkg::*;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int IN_TDATA_W = ((KEY_BITS + FUNC_W + 7) / 8) * 8;
    localparam int POOL_KEYS  = 24;
    localparam int PHASE_WORDS = 100;
    localparam int DRAIN_CYCLES = 4;

    typedef enum logic {ROW_WORD, ROW_CAP} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        t_func             func;
        logic [31:0]       key;
        logic [CAP_W-1:0]  cap;
        bit                typed;
        t_result           want;
    } t_row;

    // dut ports
    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // func [1:0], key [33:2], zero fill [39:34]
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // ok [0], was_present [1], slot [5:2], evicted [6], evicted_key [38:7],
    // count [43:39], zero fill [47:44]
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CAP_W-1:0]        i_cfg_data = '0;

    // local copy of the table
    bit               tbl_valid [ENTRIES];
    logic [31:0]      tbl_key   [ENTRIES];
    int               tbl_rank  [ENTRIES];
    int               tbl_count;
    logic [CAP_W-1:0] tbl_capacity;

    t_result     lookup_results_due[$];
    t_row        directed_rows[$];
    logic [31:0] key_pool [POOL_KEYS];
    int          mismatches;
    bit          no_idle;

    lru_replacement_table #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // hard stop well past the slowest legal run
    initial begin
        #4_000_000;
        $display("FAIL lru_replacement_table");
        $finish;
    end

    // entry leaves the table, younger-than-it ranks stay, older ones move up
    function automatic void drop_slot(int s);
        int r;
        r = tbl_rank[s];
        tbl_valid[s] = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && tbl_rank[i] > r) tbl_rank[i]--;
        tbl_rank[s] = 0;
        if (tbl_count > 0) tbl_count--;
    endfunction

    // applies one word to the local table and returns the result it implies
    function automatic t_result update_table(t_func f, logic [31:0] k);
        t_result r;
        int hit, oldest, fill, cap, rk;
        r = '0;
        if (f == FUNC_CLEAR) begin
            for (int i = 0; i < ENTRIES; i++) begin
                tbl_valid[i] = 1'b0;
                tbl_rank[i]  = 0;
            end
            tbl_count = 0;
            r.ok = 1'b1;
        end else begin
            hit = -1;
            for (int i = 0; i < ENTRIES; i++)
                if (hit < 0 && tbl_valid[i] && tbl_key[i] == k) hit = i;
            if (hit >= 0) begin
                r.ok = 1'b1;
                r.was_present = 1'b1;
                r.slot = hit[SLOT_W-1:0];
                if (f == FUNC_REMOVE) begin
                    drop_slot(hit);
                end else begin
                    rk = tbl_rank[hit];
                    for (int i = 0; i < ENTRIES; i++)
                        if (tbl_valid[i] && tbl_rank[i] < rk) tbl_rank[i]++;
                    tbl_rank[hit] = 0;
                end
            end else if (f == FUNC_ADD) begin
                // capacity 0 behaves as 1, anything above the table as full size
                cap = (tbl_capacity == 0) ? 1 :
                      (tbl_capacity > ENTRIES) ? ENTRIES : int'(tbl_capacity);
                r.ok = 1'b1;
                if (tbl_count >= cap) begin
                    oldest = -1;
                    for (int i = 0; i < ENTRIES; i++)
                        if (tbl_valid[i] && (oldest < 0 || tbl_rank[i] > tbl_rank[oldest]))
                            oldest = i;
                    if (oldest >= 0) begin
                        r.evicted = 1'b1;
                        r.evicted_key = tbl_key[oldest];
                        drop_slot(oldest);
                    end
                end
                fill = -1;
                for (int i = 0; i < ENTRIES; i++)
                    if (fill < 0 && !tbl_valid[i]) fill = i;
                if (fill >= 0) begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (tbl_valid[i]) tbl_rank[i]++;
                    tbl_valid[fill] = 1'b1;
                    tbl_key[fill]   = k;
                    tbl_rank[fill]  = 0;
                    tbl_count++;
                    r.slot = fill[SLOT_W-1:0];
                end
            end
        end
        r.count = tbl_count[COUNT_W-1:0];
        return r;
    endfunction

    function automatic t_result result_of(logic ok, logic wp, logic [3:0] slot,
                                          logic ev, logic [31:0] evk, logic [4:0] cnt);
        t_result r;
        r.ok = ok;
        r.was_present = wp;
        r.slot = slot;
        r.evicted = ev;
        r.evicted_key = evk;
        r.count = cnt;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // one word per call; the idle gap before it is random unless no_idle
    task automatic send_word(input t_func f, input logic [31:0] k,
                             input bit typed, input t_result want);
        t_result predicted;
        if (!no_idle) begin
            while ($urandom_range(99) < 32) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({k, f});
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = update_table(f, k);
        lookup_results_due.push_back(typed ? want : predicted);
    endtask

    // stop sending and let every owed result come back, plus the pipe depth
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (lookup_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] c);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= c;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tbl_capacity = c;
    endtask

    task automatic dir_word(input t_func f, input logic [31:0] k);
        t_row row;
        row = '{kind: ROW_WORD, func: f, key: k, cap: '0, typed: 1'b0, want: '0};
        directed_rows.push_back(row);
    endtask

    task automatic dir_checked(input t_func f, input logic [31:0] k, input t_result w);
        t_row row;
        row = '{kind: ROW_WORD, func: f, key: k, cap: '0, typed: 1'b1, want: w};
        directed_rows.push_back(row);
    endtask

    task automatic dir_cap(input logic [CAP_W-1:0] c);
        t_row row;
        row = '{kind: ROW_CAP, func: FUNC_ADD, key: '0, cap: c, typed: 1'b0, want: '0};
        directed_rows.push_back(row);
    endtask

    // receiver back pressure, off while no_idle holds
    always @(posedge i_clk) begin
        m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 32);
    end

    // result checker, oldest expectation first
    always @(posedge i_clk) begin : check_results
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.ok          = m_axis_tdata[0];
            got.was_present = m_axis_tdata[1];
            got.slot        = m_axis_tdata[5:2];
            got.evicted     = m_axis_tdata[6];
            got.evicted_key = m_axis_tdata[38:7];
            got.count       = m_axis_tdata[43:39];
            if (lookup_results_due.size() == 0) begin
                flag_mismatch("unexpected result word", 32'(m_axis_tdata), '0);
            end else begin
                want = lookup_results_due.pop_front();
                if (got.ok !== want.ok)
                    flag_mismatch("ok", 32'(got.ok), 32'(want.ok));
                if (got.was_present !== want.was_present)
                    flag_mismatch("was_present", 32'(got.was_present),
                                  32'(want.was_present));
                if (got.slot !== want.slot)
                    flag_mismatch("slot", 32'(got.slot), 32'(want.slot));
                if (got.evicted !== want.evicted)
                    flag_mismatch("evicted", 32'(got.evicted), 32'(want.evicted));
                if (got.evicted_key !== want.evicted_key)
                    flag_mismatch("evicted_key", got.evicted_key, want.evicted_key);
                if (got.count !== want.count)
                    flag_mismatch("count", 32'(got.count), 32'(want.count));
            end
        end
    end

    initial begin : stimulus
        logic [CAP_W-1:0] phase_caps [8];
        logic [31:0] k;
        t_func f;
        int pick;

        mismatches   = 0;
        no_idle      = 1'b0;
        tbl_capacity = CAP_RESET;
        tbl_count    = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_rank[i]  = 0;
        end
        // neighbors differ in a single bit to catch loose key compares
        for (int i = 0; i < POOL_KEYS; i++)
            key_pool[i] = (i % 2 == 1) ? key_pool[i-1] ^ (32'd1 << $urandom_range(31))
                                       : $urandom;

        // empty table at reset capacity
        dir_checked(FUNC_SEARCH, 32'h1234_5678, result_of(0, 0, 0, 0, 0, 0));
        dir_checked(FUNC_REMOVE, 32'hFFFF_FFFF, result_of(0, 0, 0, 0, 0, 0));
        dir_checked(FUNC_CLEAR,  32'hFFFF_FFFF, result_of(1, 0, 0, 0, 0, 0));
        // extreme keys, hits, remove, refill of the lowest free slot
        dir_checked(FUNC_ADD,    32'h0000_0000, result_of(1, 0, 0, 0, 0, 1));
        dir_checked(FUNC_ADD,    32'hFFFF_FFFF, result_of(1, 0, 1, 0, 0, 2));
        dir_checked(FUNC_ADD,    32'h0000_0000, result_of(1, 1, 0, 0, 0, 2));
        dir_checked(FUNC_SEARCH, 32'hFFFF_FFFF, result_of(1, 1, 1, 0, 0, 2));
        dir_checked(FUNC_REMOVE, 32'h0000_0000, result_of(1, 1, 0, 0, 0, 1));
        dir_word(FUNC_ADD, 32'hA5A5_A5A5);
        // capacity dropped below the live count: one eviction per add miss
        dir_cap(5'd1);
        dir_word(FUNC_ADD, 32'h5A5A_5A5A);
        dir_word(FUNC_ADD, 32'h0F0F_0F0F);
        dir_word(FUNC_REMOVE, 32'h5A5A_5A5A);
        // zero capacity behaves as one
        dir_cap(5'd0);
        dir_word(FUNC_ADD, 32'h1111_1111);
        dir_word(FUNC_ADD, 32'h2222_2222);
        // capacity above the table size saturates
        dir_cap(5'd31);
        dir_word(FUNC_ADD, 32'h3333_3333);
        dir_word(FUNC_ADD, 32'h4444_4444);
        dir_word(FUNC_SEARCH, 32'h3333_3333);
        dir_checked(FUNC_CLEAR,  32'h0000_0000, result_of(1, 0, 0, 0, 0, 0));
        dir_checked(FUNC_SEARCH, 32'h2222_2222, result_of(0, 0, 0, 0, 0, 0));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CAP)
                write_capacity(directed_rows[i].cap);
            else
                send_word(directed_rows[i].func, directed_rows[i].key,
                          directed_rows[i].typed, directed_rows[i].want);
        end

        // random phases; the full-size ones fill the table, the small ones
        // after them start with the count far above the capacity
        phase_caps = '{5'd16, 5'd31, 5'd5, 5'd1, 5'd0,
                       5'($urandom_range(2, 15)), 5'd16, 5'd2};
        foreach (phase_caps[p]) begin
            write_capacity(phase_caps[p]);
            no_idle = (p == 6);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // one mid-phase hold-off until the table has answered everything
                if (p == 1 && n == PHASE_WORDS / 2) drain_results();
                k = ($urandom_range(99) < 75) ? key_pool[$urandom_range(POOL_KEYS - 1)]
                                              : $urandom;
                pick = $urandom_range(99);
                if (pick < 50)      f = FUNC_ADD;
                else if (pick < 75) f = FUNC_SEARCH;
                else if (pick < 97) f = FUNC_REMOVE;
                else                f = FUNC_CLEAR;
                send_word(f, k, 1'b0, '0);
            end
        end
        no_idle = 1'b0;

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS lru_replacement_table");
        end else begin
            $display("FAIL lru_replacement_table");
        end
        $finish;
    end

endmodule : testbench
